/* rtl/idr_pkg.sv */
// Shared types, constants and helper functions for the inertial dead reckoning core.
package idr_pkg;

   localparam int CordicStepsDef = 16;

   localparam logic signed [35:0] Q29Pi     = 36'sd1686629713;
   localparam logic signed [35:0] Q29TwoPi  = 36'sd3373259426;
   localparam logic signed [35:0] Q29HalfPi = 36'sd843314857;
   localparam logic signed [33:0] Q30Gain   = 34'sd652032874;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] yaw_rate;
      logic signed [15:0] pitch_rate;
      logic        [15:0] time_step;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic        [31:0] distance;
      logic signed [31:0] heading;
      logic signed [31:0] tilt;
   } rsp_payload_type;

   // arctan(2^-i) in Q3.29
   function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
      logic signed [33:0] v;
      case (idx)
         5'd0:  v = 34'sd421657428;
         5'd1:  v = 34'sd248918915;
         5'd2:  v = 34'sd131521918;
         5'd3:  v = 34'sd66762579;
         5'd4:  v = 34'sd33510843;
         5'd5:  v = 34'sd16771758;
         5'd6:  v = 34'sd8387925;
         5'd7:  v = 34'sd4194219;
         5'd8:  v = 34'sd2097141;
         5'd9:  v = 34'sd1048575;
         5'd10: v = 34'sd524288;
         5'd11: v = 34'sd262144;
         5'd12: v = 34'sd131072;
         5'd13: v = 34'sd65536;
         5'd14: v = 34'sd32768;
         5'd15: v = 34'sd16384;
         5'd16: v = 34'sd8192;
         5'd17: v = 34'sd4096;
         5'd18: v = 34'sd2048;
         5'd19: v = 34'sd1024;
         5'd20: v = 34'sd512;
         5'd21: v = 34'sd256;
         5'd22: v = 34'sd128;
         5'd23: v = 34'sd64;
         5'd24: v = 34'sd32;
         5'd25: v = 34'sd16;
         5'd26: v = 34'sd8;
         5'd27: v = 34'sd4;
         5'd28: v = 34'sd2;
         5'd29: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/inertial_dead_reckoning_core.sv */
// Top level of the inertial dead reckoning core: sequencer around one shared multiplier.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------
//  req     | in  | req_valid / req_ready  | req_data  (one IMU sample)
//  rsp     | out | rsp_valid / rsp_ready  | rsp_data  (pose, speed, angles)
//  csr     | in  | csr_valid / csr_ready  | csr_wdata (integration mode)
//
// Each sample runs from one accepted beat to the next through the CORDIC iterations
// (CORDIC_STEPS per angle, 16 by default, two angles on one rotator), the single 33x33
// multiplier used for every product in turn and the 32-step bit-by-bit square root,
// plus one wrap pass per whole turn taken off an angle (usually none, at most two per angle).
// req_ready is high only while the sequencer is idle; the result sits in an output
// register, so a new beat may be taken while the previous result waits.
// Reset is synchronous; it clears pose, velocity and angles and sets mode to 1.
// A stalled rsp beat holds its payload until taken; the csr port is always ready.
module inertial_dead_reckoning_core
   import idr_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDef
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_wdata
);

   localparam int IterW = $clog2(CORDIC_STEPS);

   // sequencer codes
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_MUL_YAW  = 5'd1;
   localparam logic [4:0] S_ADD_YAW  = 5'd2;
   localparam logic [4:0] S_WRAP_YAW = 5'd3;
   localparam logic [4:0] S_WRAP_PIT = 5'd4;
   localparam logic [4:0] S_CORD_INI = 5'd5;
   localparam logic [4:0] S_CORD_RUN = 5'd6;
   localparam logic [4:0] S_MUL_FX   = 5'd7;
   localparam logic [4:0] S_MUL_FY   = 5'd8;
   localparam logic [4:0] S_MUL_RX   = 5'd9;
   localparam logic [4:0] S_MUL_RY   = 5'd10;
   localparam logic [4:0] S_MUL_VX   = 5'd11;
   localparam logic [4:0] S_MUL_VY   = 5'd12;
   localparam logic [4:0] S_MUL_PX   = 5'd13;
   localparam logic [4:0] S_MUL_PY   = 5'd14;
   localparam logic [4:0] S_SQ_X     = 5'd15;
   localparam logic [4:0] S_SQ_Y     = 5'd16;
   localparam logic [4:0] S_SQ_SUM   = 5'd17;
   localparam logic [4:0] S_SQRT     = 5'd18;
   localparam logic [4:0] S_OUT      = 5'd19;

   // control and architectural state
   logic [4:0]         state_ff, state_in;
   logic               mode_ff, mode_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               sel_ff, sel_in;           // 0 bearing, 1 pitch on the rotator
   logic [IterW-1:0]   iter_ff, iter_in;
   logic [4:0]         sq_cnt_ff, sq_cnt_in;
   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0] bear_ff, bear_in, pitch_ff, pitch_in;

   // working registers
   req_payload_type    req_q_ff, req_q_in;
   rsp_payload_type    rsp_q_ff, rsp_q_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [35:0] ang_ff, ang_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               neg_ff, neg_in;
   logic signed [32:0] sb_ff, sb_in, cb_ff, cb_in, cp_ff, cp_in;
   logic signed [31:0] fx_ff, fx_in, fy_ff, fy_in, rx_ff, rx_in, ry_ff, ry_in;
   logic signed [31:0] nvx_ff, nvx_in, nvy_ff, nvy_in;
   logic [63:0]        rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [32:0] dt_s;

   logic signed [35:0] fold_a;
   logic signed [33:0] dx, dy, atan_v;
   logic [63:0]        sq_t;
   logic [4:0]         vel_sh;

   assign dt_s    = $signed({17'd0, req_q_ff.time_step});
   assign prod_in = mul_a * mul_b;
   assign vel_sh  = mode_ff ? 5'd17 : 5'd16;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_YAW: begin
            mul_a = 33'(req_q_ff.yaw_rate);
            mul_b = dt_s;
         end
         S_ADD_YAW: begin
            mul_a = 33'(req_q_ff.pitch_rate);
            mul_b = dt_s;
         end
         S_WRAP_YAW: begin
            // hold the pitch product across the bearing wrap passes
            mul_a = 33'(req_q_ff.pitch_rate);
            mul_b = dt_s;
         end
         S_MUL_FX: begin
            mul_a = cp_ff;
            mul_b = sb_ff;
         end
         S_MUL_FY: begin
            mul_a = cp_ff;
            mul_b = cb_ff;
         end
         S_MUL_RX: begin
            mul_a = 33'(req_q_ff.accel_x);
            mul_b = 33'(fx_ff);
         end
         S_MUL_RY: begin
            mul_a = 33'(req_q_ff.accel_y);
            mul_b = 33'(fy_ff);
         end
         S_MUL_VX: begin
            mul_a = mode_ff ? (33'(req_q_ff.accel_x) <<< 8) + 33'(rx_ff) : 33'(rx_ff);
            mul_b = dt_s;
         end
         S_MUL_VY: begin
            mul_a = mode_ff ? (33'(req_q_ff.accel_y) <<< 8) + 33'(ry_ff) : 33'(ry_ff);
            mul_b = dt_s;
         end
         S_MUL_PX: begin
            mul_a = mode_ff ? 33'(vel_x_ff) : 33'(nvx_ff);
            mul_b = dt_s;
         end
         S_MUL_PY: begin
            mul_a = mode_ff ? 33'(vel_y_ff) : 33'(nvy_ff);
            mul_b = dt_s;
         end
         S_SQ_X: begin
            mul_a = 33'(pos_x_ff);
            mul_b = 33'(pos_x_ff);
         end
         S_SQ_Y: begin
            mul_a = 33'(pos_y_ff);
            mul_b = 33'(pos_y_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // rotator and root step helpers
   assign fold_a = sel_ff ? 36'(pitch_ff) : 36'(bear_ff);
   assign dx     = cy_ff >>> iter_ff;
   assign dy     = cx_ff >>> iter_ff;
   assign atan_v = atan_lut(5'(iter_ff));
   assign sq_t   = root_ff + bit_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff;
      sel_in       = sel_ff;
      iter_in      = iter_ff;
      sq_cnt_in    = sq_cnt_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      bear_in      = bear_ff;
      pitch_in     = pitch_ff;
      req_q_in     = req_q_ff;
      rsp_q_in     = rsp_q_ff;
      ang_in       = ang_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      neg_in       = neg_ff;
      sb_in        = sb_ff;
      cb_in        = cb_ff;
      cp_in        = cp_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      nvx_in       = nvx_ff;
      nvy_in       = nvy_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;

      if (csr_valid) begin
         mode_in = csr_wdata;
      end
      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_q_in = req_data;
               state_in = S_MUL_YAW;
            end
         end
         S_MUL_YAW: state_in = S_ADD_YAW;
         S_ADD_YAW: begin
            ang_in   = 36'(bear_ff) + 36'(prod_ff <<< 1);
            state_in = S_WRAP_YAW;
         end
         S_WRAP_YAW: begin
            if (ang_ff >= Q29Pi) begin
               ang_in = ang_ff - Q29TwoPi;
            end else if (ang_ff < -Q29Pi) begin
               ang_in = ang_ff + Q29TwoPi;
            end else begin
               bear_in  = ang_ff[31:0];
               ang_in   = 36'(pitch_ff) + 36'(prod_ff <<< 1);
               state_in = S_WRAP_PIT;
            end
         end
         S_WRAP_PIT: begin
            if (ang_ff >= Q29Pi) begin
               ang_in = ang_ff - Q29TwoPi;
            end else if (ang_ff < -Q29Pi) begin
               ang_in = ang_ff + Q29TwoPi;
            end else begin
               pitch_in = ang_ff[31:0];
               sel_in   = 1'b0;
               state_in = S_CORD_INI;
            end
         end
         S_CORD_INI: begin
            // fold into [-pi/2, pi/2]; a half turn flips both sin and cos
            cx_in   = Q30Gain;
            cy_in   = '0;
            iter_in = '0;
            if (fold_a > Q29HalfPi) begin
               cz_in  = 34'(fold_a - Q29Pi);
               neg_in = 1'b1;
            end else if (fold_a < -Q29HalfPi) begin
               cz_in  = 34'(fold_a + Q29Pi);
               neg_in = 1'b1;
            end else begin
               cz_in  = 34'(fold_a);
               neg_in = 1'b0;
            end
            state_in = S_CORD_RUN;
         end
         S_CORD_RUN: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - atan_v;
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + atan_v;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IterW'(CORDIC_STEPS - 1)) begin
               if (!sel_ff) begin
                  sb_in    = neg_ff ? -33'(cy_in) : 33'(cy_in);
                  cb_in    = neg_ff ? -33'(cx_in) : 33'(cx_in);
                  sel_in   = 1'b1;
                  state_in = S_CORD_INI;
               end else begin
                  cp_in    = neg_ff ? -33'(cx_in) : 33'(cx_in);
                  state_in = S_MUL_FX;
               end
            end
         end
         S_MUL_FX: state_in = S_MUL_FY;
         S_MUL_FY: begin
            fx_in    = 32'(prod_ff >>> 30);
            state_in = S_MUL_RX;
         end
         S_MUL_RX: begin
            fy_in    = 32'(prod_ff >>> 30);
            state_in = S_MUL_RY;
         end
         S_MUL_RY: begin
            rx_in    = 32'(prod_ff >>> 22);
            state_in = S_MUL_VX;
         end
         S_MUL_VX: begin
            ry_in    = 32'(prod_ff >>> 22);
            state_in = S_MUL_VY;
         end
         S_MUL_VY: begin
            nvx_in   = sat32(40'(vel_x_ff) + 40'(prod_ff >>> vel_sh));
            state_in = S_MUL_PX;
         end
         S_MUL_PX: begin
            nvy_in   = sat32(40'(vel_y_ff) + 40'(prod_ff >>> vel_sh));
            state_in = S_MUL_PY;
         end
         S_MUL_PY: begin
            pos_x_in = sat32(40'(pos_x_ff) + 40'(prod_ff >>> 16));
            state_in = S_SQ_X;
         end
         S_SQ_X: begin
            pos_y_in = sat32(40'(pos_y_ff) + 40'(prod_ff >>> 16));
            vel_x_in = nvx_ff;
            vel_y_in = nvy_ff;
            state_in = S_SQ_Y;
         end
         S_SQ_Y: begin
            rem_in   = 64'(prod_ff);
            state_in = S_SQ_SUM;
         end
         S_SQ_SUM: begin
            rem_in    = rem_ff + 64'(prod_ff);
            root_in   = '0;
            bit_in    = 64'd1 << 62;
            sq_cnt_in = '0;
            state_in  = S_SQRT;
         end
         S_SQRT: begin
            if (rem_ff >= sq_t) begin
               rem_in  = rem_ff - sq_t;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in    = bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (sq_cnt_ff == 5'd31) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold here while the previous result is still unclaimed
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_q_in.pos_x    = pos_x_ff;
               rsp_q_in.pos_y    = pos_y_ff;
               rsp_q_in.vel_x    = vel_x_ff;
               rsp_q_in.vel_y    = vel_y_ff;
               rsp_q_in.distance = root_ff[31:0];
               rsp_q_in.heading  = bear_ff;
               rsp_q_in.tilt     = pitch_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         iter_ff      <= '0;
         sq_cnt_ff    <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         bear_ff      <= '0;
         pitch_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         iter_ff      <= iter_in;
         sq_cnt_ff    <= sq_cnt_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         bear_ff      <= bear_in;
         pitch_ff     <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      req_q_ff <= req_q_in;
      rsp_q_ff <= rsp_q_in;
      prod_ff  <= prod_in;
      ang_ff   <= ang_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      neg_ff   <= neg_in;
      sb_ff    <= sb_in;
      cb_ff    <= cb_in;
      cp_ff    <= cp_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      nvx_ff   <= nvx_in;
      nvy_ff   <= nvy_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_q_ff;
   assign csr_ready = 1'b1;

   // one sample at a time: busy right after a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a sample is in flight");

   // a new result only comes out of the output state
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the output state");

   // delivered angles are wrapped to [-pi, pi)
   a_heading_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (36'(rsp_q_ff.heading) < Q29Pi && 36'(rsp_q_ff.heading) >= -Q29Pi))
      else $error("heading out of range");

   a_tilt_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (36'(rsp_q_ff.tilt) < Q29Pi && 36'(rsp_q_ff.tilt) >= -Q29Pi))
      else $error("tilt out of range");

endmodule

/* tb/inertial_dead_reckoning_core_tb.sv */
// Self-checking testbench for the inertial dead reckoning core.
module inertial_dead_reckoning_core_tb;
   import idr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_EULER = 1'b0;
   localparam logic MODE_TRAPEZOID = 1'b1;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_SAMPLES = 1130;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_START = 300;
   localparam int HOLD_CYCLES = 700;

   // arctan(2^-i) in Q3.29, one entry per rotation
   localparam longint ATAN_Q29[32] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
      8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
      8, 4, 2, 1, 0, 0};

   typedef enum logic {JOB_SAMPLE, JOB_MODE} job_kind_type;
   typedef struct {
      job_kind_type    kind;
      logic            mode;
      req_payload_type sample;
   } job_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic            csr_wdata;

   job_type         job_q[$];
   rsp_payload_type pose_q[$];
   int              errors = 0;
   int              cycles = 0;
   int              samples_taken = 0;
   int              poses_seen = 0;
   bit              req_taken = 0;
   bit              csr_taken = 0;
   bit              hold_done = 0;
   int              hold_left = 0;

   // predictor state
   int              pos_x_st, pos_y_st, vel_x_st, vel_y_st, bearing_st, pitch_st;
   logic            mode_st;

   inertial_dead_reckoning_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   // wrap by whole turns into [-pi, pi)
   function automatic int wrap_turns(input longint a);
      while (a >= longint'(Q29Pi)) a -= longint'(Q29TwoPi);
      while (a < -longint'(Q29Pi)) a += longint'(Q29TwoPi);
      return int'(a);
   endfunction

   // sin and cos as Q30; fold into the right half plane first
   function automatic void rotate_unit(input longint a, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit     flip;
      x = longint'(Q30Gain);
      y = 0;
      flip = 1'b0;
      if (a > longint'(Q29HalfPi)) begin
         a -= longint'(Q29Pi);
         flip = 1'b1;
      end else if (a < -longint'(Q29HalfPi)) begin
         a += longint'(Q29Pi);
         flip = 1'b1;
      end
      z = a;
      for (int i = 0; i < CordicStepsDef && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ATAN_Q29[i];
         end else begin
            x += dx;
            y -= dy;
            z += ATAN_Q29[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // advance the pose by one sample and return the expected beat
   function automatic rsp_payload_type advance_pose(input req_payload_type p);
      longint ax, ay, yr, pr, dt, sb, cb, sp, cp, fx, fy, rx, ry, vx, vy, px, py;
      longint unsigned sq;
      rsp_payload_type r;
      ax = longint'(p.accel_x);
      ay = longint'(p.accel_y);
      yr = longint'(p.yaw_rate);
      pr = longint'(p.pitch_rate);
      dt = longint'(p.time_step);
      bearing_st = wrap_turns(longint'(bearing_st) + yr * dt * 2);
      pitch_st = wrap_turns(longint'(pitch_st) + pr * dt * 2);
      rotate_unit(longint'(bearing_st), sb, cb);
      rotate_unit(longint'(pitch_st), sp, cp);
      fx = (cp * sb) >>> 30;
      fy = (cp * cb) >>> 30;
      rx = (ax * fx) >>> 22;
      ry = (ay * fy) >>> 22;
      vx = vel_x_st;
      vy = vel_y_st;
      px = pos_x_st;
      py = pos_y_st;
      if (mode_st == MODE_EULER) begin
         vel_x_st = clamp32(vx + ((rx * dt) >>> 16));
         vel_y_st = clamp32(vy + ((ry * dt) >>> 16));
         pos_x_st = clamp32(px + ((longint'(vel_x_st) * dt) >>> 16));
         pos_y_st = clamp32(py + ((longint'(vel_y_st) * dt) >>> 16));
      end else begin
         vel_x_st = clamp32(vx + (((ax * 256 + rx) * dt) >>> 17));
         vel_y_st = clamp32(vy + (((ay * 256 + ry) * dt) >>> 17));
         pos_x_st = clamp32(px + ((vx * dt) >>> 16));
         pos_y_st = clamp32(py + ((vy * dt) >>> 16));
      end
      sq = unsigned'(longint'(pos_x_st) * pos_x_st) +
           unsigned'(longint'(pos_y_st) * pos_y_st);
      r.pos_x = pos_x_st;
      r.pos_y = pos_y_st;
      r.vel_x = vel_x_st;
      r.vel_y = vel_y_st;
      r.distance = 32'(root_floor(sq));
      r.heading = bearing_st;
      r.tilt = pitch_st;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
         errors++;
      end
   endfunction

   function automatic void add_sample(input int ax, ay, yr, pr, dt);
      job_type j;
      j.kind = JOB_SAMPLE;
      j.mode = MODE_EULER;
      j.sample.accel_x = 16'(ax);
      j.sample.accel_y = 16'(ay);
      j.sample.yaw_rate = 16'(yr);
      j.sample.pitch_rate = 16'(pr);
      j.sample.time_step = 16'(dt);
      job_q.push_back(j);
   endfunction

   function automatic void add_mode(input logic m);
      job_type j;
      j.kind = JOB_MODE;
      j.mode = m;
      j.sample = '0;
      job_q.push_back(j);
   endfunction

   // mostly moderate motion, a quarter of fully random beats
   function automatic void add_random_sample();
      if ($urandom_range(3) == 0) begin
         add_sample($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         add_sample($urandom_range(4096) - 2048, $urandom_range(4096) - 2048,
                    $urandom_range(16384) - 8192, $urandom_range(16384) - 8192,
                    ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(4096));
      end
   endfunction

   // stimulus: directed corners, then random phases with mode changes between them
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = 1'b0;
      mode_st = MODE_TRAPEZOID;
      pos_x_st = 0;
      pos_y_st = 0;
      vel_x_st = 0;
      vel_y_st = 0;
      bearing_st = 0;
      pitch_st = 0;

      // reset mode is trapezoid: run corners in it first
      add_sample(0, 0, 0, 0, 0);
      add_sample(32767, -32768, 0, 0, 65535);
      add_sample(-32768, 32767, 32767, -32768, 65535);
      add_sample(32767, 32767, -32768, 32767, 65535);
      add_sample(256, 256, 6434, 0, 32768);
      add_sample(-256, 512, 0, 6434, 32768);
      add_sample(1000, -1000, 12868, 12868, 65535);
      add_sample(32767, 32767, 0, 0, 0);
      add_sample(-32768, -32768, 0, 0, 1);
      add_sample(32767, 32767, 32767, 32767, 65535);
      add_sample(32767, -32768, 0, 0, 65535);
      add_mode(MODE_EULER);
      add_sample(-32768, -32768, -32768, -32768, 65535);
      add_sample(32767, 32767, 32767, 32767, 65535);
      add_sample(0, 0, 3217, -3217, 65535);
      add_sample(-32768, 32767, 0, 0, 65535);
      add_sample(32767, -32768, 0, 0, 65535);
      add_sample(12345, -12345, 100, -100, 1);
      add_sample(-1, 1, -1, 1, 65535);
      add_sample(32767, 32767, 32767, 32767, 0);
      add_sample(0, 0, 0, 0, 65535);

      for (int ph = 0; ph < 5; ph++) begin
         add_mode((ph % 2 == 0) ? MODE_TRAPEZOID : MODE_EULER);
         for (int k = 0; k < RANDOM_SAMPLES / 5; k++) add_random_sample();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (job_q.size() == 0 && !req_valid && !csr_valid && pose_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pose_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // accept beats and run the predictor at the edge they are taken
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            pose_q.push_back(advance_pose(req_data));
            samples_taken++;
            req_taken = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            mode_st = csr_wdata;
            csr_taken = 1'b1;
         end
      end
   end

   // driver: hold each beat until taken, then idle at random or present the next job
   always @(negedge clock) begin
      logic            nxt_req_valid;
      logic            nxt_csr_valid;
      logic            nxt_mode;
      req_payload_type nxt_data;
      bit              busy;
      bit              steady;
      nxt_req_valid = req_valid;
      nxt_csr_valid = csr_valid;
      nxt_mode = csr_wdata;
      nxt_data = req_data;
      busy = (req_valid && !req_taken) || (csr_valid && !csr_taken);
      steady = samples_taken >= 500 && samples_taken < 700;
      if (!reset && !busy) begin
         nxt_req_valid = 1'b0;
         nxt_csr_valid = 1'b0;
         if (job_q.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
            if (job_q[0].kind == JOB_SAMPLE) begin
               nxt_data = job_q[0].sample;
               nxt_req_valid = 1'b1;
               void'(job_q.pop_front());
            end else if (pose_q.size() == 0 && !req_valid) begin
               // change mode only once the core has drained
               nxt_mode = job_q[0].mode;
               nxt_csr_valid = 1'b1;
               void'(job_q.pop_front());
            end
         end
         req_taken = 1'b0;
         csr_taken = 1'b0;
      end
      req_valid <= nxt_req_valid;
      req_data <= nxt_data;
      csr_valid <= nxt_csr_valid;
      csr_wdata <= nxt_mode;
   end

   // receiver backpressure: random stalls, a quiet window, and one long hold-off
   always @(negedge clock) begin
      logic nxt_ready;
      if (reset) begin
         nxt_ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         nxt_ready = 1'b0;
      end else if (!hold_done && poses_seen >= HOLD_START) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         nxt_ready = 1'b0;
      end else begin
         nxt_ready = (samples_taken >= 500 && samples_taken < 700) || $urandom_range(99) >= 20;
      end
      rsp_ready <= nxt_ready;
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         poses_seen++;
         if (pose_q.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $realtime,
                     rsp_data);
            errors++;
         end else begin
            want = pose_q.pop_front();
            compare_field("pos_x", want.pos_x, rsp_data.pos_x);
            compare_field("pos_y", want.pos_y, rsp_data.pos_y);
            compare_field("vel_x", want.vel_x, rsp_data.vel_x);
            compare_field("vel_y", want.vel_y, rsp_data.vel_y);
            compare_field("distance", want.distance, rsp_data.distance);
            compare_field("heading", want.heading, rsp_data.heading);
            compare_field("tilt", want.tilt, rsp_data.tilt);
         end
      end
   end

endmodule

/* inertial_dead_reckoning_core.f */
rtl/idr_pkg.sv
rtl/inertial_dead_reckoning_core.sv
tb/inertial_dead_reckoning_core_tb.sv
